// File: src/gbcd_pkg.sv
`timescale 1ns / 1ps
// gbcd_pkg: shared types and constants for the gyro bias calibration block
// no dependencies

package gbcd_pkg;

    localparam int DATA_W    = 16;
    localparam int SUM_W     = 23;
    localparam int AXES      = 3;
    localparam int CAL_LEN   = 128;
    localparam int CNT_W     = $clog2(CAL_LEN);
    localparam int CAL_SHIFT = 7;

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef struct packed {
        logic take;
        logic clear;
        logic cal;
        logic finish;
    } lane_ctl_t;

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t z;
    } result_t;

endpackage

// File: src/gbcd_if.sv
`timescale 1ns / 1ps
// gbcd_in_if and gbcd_out_if: valid/ready channels for samples and results
// depends on gbcd_pkg

interface gbcd_in_if
    import gbcd_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    recalibrate;
    sample_t x_raw;
    sample_t y_raw;
    sample_t z_raw;

    modport source (output valid, output recalibrate, output x_raw, output y_raw,
                    output z_raw, input ready);
    modport sink   (input valid, input recalibrate, input x_raw, input y_raw,
                    input z_raw, output ready);
endinterface

interface gbcd_out_if
    import gbcd_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t x_out;
    sample_t y_out;
    sample_t z_out;

    modport source (output valid, output x_out, output y_out, output z_out,
                    input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    output ready);
endinterface

// File: src/gbcd_lane.sv
`timescale 1ns / 1ps
// gbcd_lane: per-axis sum, running max threshold, offset and deadband output
// depends on gbcd_pkg

module gbcd_lane
    import gbcd_pkg::*;
#(
    parameter int SHIFT = CAL_SHIFT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  lane_ctl_t ctl,
    input  sample_t   raw,
    output sample_t   result
);

    localparam logic signed [SUM_W-1:0] OFF_MAX = SUM_W'((2 ** (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] OFF_MIN = -SUM_W'(2 ** (DATA_W - 1));

    logic signed [SUM_W-1:0] sum_reg, sum_next, sum_base, shifted;
    sample_t                 thr_reg, thr_next, thr_base;
    sample_t                 off_reg, off_next, off_calc;
    sample_t                 diff;
    logic [DATA_W:0]         diff_mag;

    always_comb
    begin
        sum_base = ctl.clear ? '0 : sum_reg;
        thr_base = ctl.clear ? '0 : thr_reg;
        shifted  = (sum_base + SUM_W'(raw)) >>> SHIFT;
        if (shifted > OFF_MAX)
        begin
            off_calc = sample_t'(OFF_MAX);
        end
        else if (shifted < OFF_MIN)
        begin
            off_calc = sample_t'(OFF_MIN);
        end
        else
        begin
            off_calc = shifted[DATA_W-1:0];
        end
        sum_next = sum_reg;
        thr_next = thr_reg;
        off_next = off_reg;
        if (ctl.take && ctl.cal)
        begin
            sum_next = sum_base + SUM_W'(raw);
            thr_next = (raw > thr_base) ? raw : thr_base;
            if (ctl.finish)
            begin
                off_next = off_calc;
            end
        end
    end

    // deadband on the offset-corrected sample
    always_comb
    begin
        diff     = raw - off_reg;
        diff_mag = diff[DATA_W-1] ? (DATA_W+1)'(-{diff[DATA_W-1], diff})
                                  : {1'b0, diff};
        result   = (diff_mag < {1'b0, thr_reg}) ? '0 : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            thr_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            thr_reg <= thr_next;
            off_reg <= off_next;
        end
    end

endmodule

// File: src/gbcd_out.sv
`timescale 1ns / 1ps
// gbcd_out: merges lane results into one output register with a skid stage
// depends on gbcd_pkg and gbcd_out_if

module gbcd_out
    import gbcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t data,
    output logic    room,
    gbcd_out_if.source result
);

    result_t out_reg, out_next, skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic    pop;

    assign room          = !skid_valid_reg;
    assign pop           = out_valid_reg && result.ready;
    assign result.valid  = out_valid_reg;
    assign result.x_out  = out_reg.x;
    assign result.y_out  = out_reg.y;
    assign result.z_out  = out_reg.z;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next = data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_next       = data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// File: src/gyro_bias_calibrate_deadband.sv
`timescale 1ns / 1ps
// gyro_bias_calibrate_deadband: top level, run counter, three axis lanes, output stage
// depends on gbcd_pkg, gbcd_if, gbcd_lane, gbcd_out
// results are registered in the output stage; calibration samples give no result
// throughput: one sample per cycle while the output stage has room
// a two-entry output stage keeps taking samples while a result waits
// reset: clears sums, thresholds, offsets and count; first 128 samples calibrate

module gyro_bias_calibrate_deadband
    import gbcd_pkg::*;
#(
    parameter int SHIFT = CAL_SHIFT
) (
    input  logic clk,
    input  logic rst_n,
    gbcd_in_if.sink    sample,
    gbcd_out_if.source result
);

    logic [CNT_W-1:0] count_reg, count_next, count_base;
    logic             calibrated_reg, calibrated_next;
    logic             take, room;
    lane_ctl_t        ctl;
    sample_t          raw   [AXES];
    sample_t          lane_q[AXES];
    result_t          merged;

    assign sample.ready = room;
    assign take         = sample.valid && room;
    assign raw[0]       = sample.x_raw;
    assign raw[1]       = sample.y_raw;
    assign raw[2]       = sample.z_raw;

    always_comb
    begin
        count_base      = sample.recalibrate ? '0 : count_reg;
        ctl.take        = take;
        ctl.clear       = sample.recalibrate;
        ctl.cal         = sample.recalibrate || !calibrated_reg;
        ctl.finish      = (count_base == CNT_W'(CAL_LEN - 1));
        count_next      = count_reg;
        calibrated_next = calibrated_reg;
        if (take && ctl.cal)
        begin
            count_next      = ctl.finish ? '0 : count_base + 1'b1;
            calibrated_next = ctl.finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            calibrated_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            calibrated_reg <= calibrated_next;
        end
    end

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        gbcd_lane #(
            .SHIFT (SHIFT)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .raw    (raw[i]),
            .result (lane_q[i])
        );
    end

    assign merged.x = lane_q[0];
    assign merged.y = lane_q[1];
    assign merged.z = lane_q[2];

    gbcd_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take && !ctl.cal),
        .data   (merged),
        .room   (room),
        .result (result)
    );

endmodule
